### rtl/core/sti_pkg.sv
// Shared types and constants for the sorted top-k insertion table.
`default_nettype none

package sti_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 128;

   // Fixed field widths
   localparam int POINTS_W  = 16;
   localparam int ELAPSED_W = 32;
   localparam int COUNT8_W  = 8;
   localparam int RD_IDX_W  = 7;
   localparam int PLACED_W  = 7;
   localparam int TOTAL_W   = 8;

   // Request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // One stored record
   typedef struct packed {
      logic signed [POINTS_W-1:0]  points;
      logic        [ELAPSED_W-1:0] elapsed;
      logic        [COUNT8_W-1:0]  hits;
      logic        [COUNT8_W-1:0]  misses;
      logic        [COUNT8_W-1:0]  bonus;
   } record_type;

endpackage

`default_nettype wire

### rtl/core/sorted_top_k_insert.sv
// Top level of the sorted top-k insertion table.
//
// Keeps up to CAPACITY records sorted by descending points. A request word is
// taken when start is high and busy is low. req_type selects insert or read.
// An insert with positive points goes ahead of the first entry with smaller
// points; later entries move down one and the tail drops when full.
// Each request gives one result word on the rsp_ ports, marked by rsp_valid
// for exactly one cycle; the receiver cannot stall it.
// Sequence: a rejected insert (points not positive) is answered straight from
// idle; a read goes through the registered memory read and then gives its
// result; an insert fetches and compares each entry scanned, reads and writes
// each entry moved, then places the record, or is discarded at the end of the
// scan when the table is full and no stored key is smaller.
// The rate is set by the record memory, with one write port and one
// registered read port, and the one key comparator, used once per step.
// busy stays high until the result is issued; one request is in work at a time.
// Reset clears the entry count; record memory contents are not cleared.
`default_nettype none

module sorted_top_k_insert
   import sti_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic                        req_type,
   input  wire logic signed [POINTS_W-1:0]  req_new_points,
   input  wire logic [ELAPSED_W-1:0]        req_new_elapsed,
   input  wire logic [COUNT8_W-1:0]         req_new_hits,
   input  wire logic [COUNT8_W-1:0]         req_new_misses,
   input  wire logic [COUNT8_W-1:0]         req_new_bonus,
   input  wire logic [RD_IDX_W-1:0]         req_read_index,
   output      logic                        rsp_valid,
   output      logic                        rsp_accepted,
   output      logic [PLACED_W-1:0]         rsp_placed_at,
   output      logic [TOTAL_W-1:0]          rsp_entry_total,
   output      logic                        rsp_rd_valid,
   output      logic signed [POINTS_W-1:0]  rsp_rd_points,
   output      logic [ELAPSED_W-1:0]        rsp_rd_elapsed,
   output      logic [COUNT8_W-1:0]         rsp_rd_hits,
   output      logic [COUNT8_W-1:0]         rsp_rd_misses,
   output      logic [COUNT8_W-1:0]         rsp_rd_bonus
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   record_type       req_rec;
   record_type       rd_rec;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   record_type       mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   record_type       mem_rd_data;

   // Pack the request word
   always_comb begin
      req_rec.points  = req_new_points;
      req_rec.elapsed = req_new_elapsed;
      req_rec.hits    = req_new_hits;
      req_rec.misses  = req_new_misses;
      req_rec.bonus   = req_new_bonus;
   end

   sti_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_rec         (req_rec),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_accepted    (rsp_accepted),
      .rsp_placed_at   (rsp_placed_at),
      .rsp_entry_total (rsp_entry_total),
      .rsp_rd_valid    (rsp_rd_valid),
      .rsp_rd_rec      (rd_rec),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   sti_store #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Unpack the read word
   assign rsp_rd_points  = rd_rec.points;
   assign rsp_rd_elapsed = rd_rec.elapsed;
   assign rsp_rd_hits    = rd_rec.hits;
   assign rsp_rd_misses  = rd_rec.misses;
   assign rsp_rd_bonus   = rd_rec.bonus;

endmodule

`default_nettype wire

### rtl/core/sti_store.sv
// Record memory: one write port, one registered read port.
`default_nettype none

module sti_store
   import sti_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire record_type       wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      record_type       rd_data
);

   record_type store_ff [CAPACITY];
   record_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/sti_ctrl.sv
// Sequencer: scans with one key comparator, shifts entries, places records, serves reads.
`default_nettype none

module sti_ctrl
   import sti_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request side
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic                         req_type,
   input  wire record_type                   req_rec,
   input  wire logic [RD_IDX_W-1:0]          req_read_index,
   // result side
   output      logic                         rsp_valid,
   output      logic                         rsp_accepted,
   output      logic [PLACED_W-1:0]          rsp_placed_at,
   output      logic [TOTAL_W-1:0]           rsp_entry_total,
   output      logic                         rsp_rd_valid,
   output      record_type                   rsp_rd_rec,
   // memory side
   output      logic                         mem_wr_en,
   output      logic [IDX_W-1:0]             mem_wr_addr,
   output      record_type                   mem_wr_data,
   output      logic                         mem_rd_en,
   output      logic [IDX_W-1:0]             mem_rd_addr,
   input  wire record_type                   mem_rd_data
);

   localparam int CMP_W = (CNT_W > RD_IDX_W) ? CNT_W : RD_IDX_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_READ     = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CMP = 3'd3;
   localparam logic [2:0] S_SHIFT_RD = 3'd4;
   localparam logic [2:0] S_SHIFT_WR = 3'd5;
   localparam logic [2:0] S_PLACE    = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   record_type          rec_ff, rec_in;
   logic                hit_ff, hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                acc_ff, acc_in;
   logic [PLACED_W-1:0] placed_ff, placed_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rdv_ff, rdv_in;
   record_type          rd_rec_ff, rd_rec_in;

   logic                has_room;
   logic                key_smaller;
   logic [CNT_W-1:0]    ptr_dec;

   // Shared compare unit
   assign has_room    = (cnt_ff < CAP_CNT);
   assign key_smaller = (mem_rd_data.points < rec_ff.points);
   assign ptr_dec     = ptr_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      rec_in       = rec_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      acc_in       = acc_ff;
      placed_in    = placed_ff;
      total_in     = total_ff;
      rdv_in       = rdv_ff;
      rd_rec_in    = rd_rec_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff;
      mem_wr_data  = rec_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = IDX_W'(ptr_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rec_in = req_rec;
               ptr_in = '0;
               if (req_type == REQ_READ) begin
                  hit_in      = (CMP_W'(req_read_index) < CMP_W'(cnt_ff));
                  mem_rd_en   = hit_in;
                  mem_rd_addr = IDX_W'(req_read_index);
                  state_in    = S_READ;
               end else if (req_rec.points > 0) begin
                  state_in = S_SCAN_RD;
               end else begin
                  // non-positive key: reject at once
                  rsp_valid_in = 1'b1;
                  acc_in       = 1'b0;
                  placed_in    = '0;
                  total_in     = TOTAL_W'(cnt_ff);
                  rdv_in       = 1'b0;
                  rd_rec_in    = '0;
               end
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            acc_in       = 1'b0;
            placed_in    = '0;
            total_in     = TOTAL_W'(cnt_ff);
            rdv_in       = hit_ff;
            rd_rec_in    = hit_ff ? mem_rd_data : '0;
            state_in     = S_IDLE;
         end

         // fetch next stored key, or end of list
         S_SCAN_RD: begin
            if (ptr_ff == cnt_ff) begin
               if (has_room) begin
                  pos_in   = IDX_W'(cnt_ff);
                  state_in = S_PLACE;
               end else begin
                  // full and no smaller key: discard
                  rsp_valid_in = 1'b1;
                  acc_in       = 1'b0;
                  placed_in    = '0;
                  total_in     = TOTAL_W'(cnt_ff);
                  rdv_in       = 1'b0;
                  rd_rec_in    = '0;
                  state_in     = S_IDLE;
               end
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            if (key_smaller) begin
               pos_in   = IDX_W'(ptr_ff);
               // last destination slot of the shift
               ptr_in   = has_room ? cnt_ff : cnt_ff - CNT_W'(1);
               state_in = S_SHIFT_RD;
            end else begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end

         // move entry ptr-1 down to ptr, from the tail up
         S_SHIFT_RD: begin
            if (ptr_ff > CNT_W'(pos_ff)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(ptr_dec);
               state_in    = S_SHIFT_WR;
            end else begin
               state_in = S_PLACE;
            end
         end

         S_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = IDX_W'(ptr_ff);
            mem_wr_data = mem_rd_data;
            ptr_in      = ptr_dec;
            state_in    = S_SHIFT_RD;
         end

         S_PLACE: begin
            mem_wr_en    = 1'b1;
            cnt_in       = has_room ? cnt_ff + CNT_W'(1) : cnt_ff;
            rsp_valid_in = 1'b1;
            acc_in       = 1'b1;
            placed_in    = PLACED_W'(pos_ff);
            total_in     = TOTAL_W'(cnt_in);
            rdv_in       = 1'b0;
            rd_rec_in    = '0;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result words
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      rec_ff    <= rec_in;
      hit_ff    <= hit_in;
      acc_ff    <= acc_in;
      placed_ff <= placed_in;
      total_ff  <= total_in;
      rdv_ff    <= rdv_in;
      rd_rec_ff <= rd_rec_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_placed_at   = placed_ff;
   assign rsp_entry_total = total_ff;
   assign rsp_rd_valid    = rdv_ff;
   assign rsp_rd_rec      = rd_rec_ff;

endmodule

`default_nettype wire
